// ===== rtl/aarm_pkg.sv =====
// Shared types and constants for the axis-angle rotation matrix unit.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package aarm_pkg;

    // Parameter defaults for the top level.
    localparam int FRAC_BITS_DEF     = 14;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int AXIS_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int ENTRY_W     = 16;
    localparam int NUM_ENTRIES = 9;
    localparam int S_TDATA_W   = 3 * AXIS_W + ANGLE_W;
    localparam int M_TDATA_W   = NUM_ENTRIES * ENTRY_W;

    // CORDIC datapath: Q.30 coordinates and angle in 2^-32 turn units.
    localparam int CORD_W     = 32;
    localparam int TURN_W     = 32;
    localparam int ATAN_DEPTH = 32;

    // CORDIC gain compensation, 0.60725... in Q.30.
    localparam logic signed [CORD_W-1:0] GAIN_Q30 = 32'sd652032874;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic signed [CORD_W-1:0] ATAN_TURN32 [ATAN_DEPTH] = '{
        32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2E, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
        32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051,
        32'sh00000028, 32'sh00000014, 32'sh0000000A, 32'sh00000005,
        32'sh00000002, 32'sh00000001, 32'sh00000000, 32'sh00000000
    };

    // Quadrant of the input angle, taken from its top two bits.
    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } quad_t;

    // Beat carried from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
        quad_t                    quad;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
    } cord_t;

endpackage

`default_nettype wire

// ===== rtl/aarm_cordic_cell.sv =====
// One rotation-mode CORDIC cell with its own output register and handshake.
// Depends on aarm_pkg for the beat type and the arctangent table.
`default_nettype none

module aarm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire aarm_pkg::cord_t  in_data,
    output logic                  out_valid,
    input  wire                   out_ready,
    output aarm_pkg::cord_t       out_data
);

    logic            valid_reg;
    aarm_pkg::cord_t data_reg;
    aarm_pkg::cord_t data_next;
    logic signed [aarm_pkg::CORD_W-1:0] dx;
    logic signed [aarm_pkg::CORD_W-1:0] dy;

    // The cell takes a new beat whenever its register is empty or drains.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Micro-rotation: the sign of the residual angle picks the direction.
    assign dx = in_data.y >>> STAGE;
    assign dy = in_data.x >>> STAGE;

    always_comb begin
        data_next = in_data;
        if (!in_data.z[aarm_pkg::CORD_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - aarm_pkg::ATAN_TURN32[STAGE];
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + aarm_pkg::ATAN_TURN32[STAGE];
        end
    end

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aarm_matrix.sv =====
// Rodrigues matrix builder: quadrant map, rounding, products, sums, saturation.
// Five pipeline stages with an elastic handshake; depends on aarm_pkg.
`default_nettype none

module aarm_matrix #(
    parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire aarm_pkg::cord_t             in_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [aarm_pkg::M_TDATA_W-1:0]   out_data
);

    localparam int NS      = 5;
    localparam int W33     = aarm_pkg::CORD_W + 1;
    localparam int RND_SH  = 30 - FRAC_BITS;
    localparam int C_W     = FRAC_BITS + 3;
    localparam int PQ_W    = 2 * aarm_pkg::AXIS_W;
    localparam int SP_W    = aarm_pkg::AXIS_W + C_W;
    localparam int PT_W    = PQ_W + C_W;
    localparam int T_A     = (C_W > 37 - FRAC_BITS) ? C_W : 37 - FRAC_BITS;
    localparam int TERM_W  = (T_A > 18) ? T_A : 18;
    localparam int SUM_W   = TERM_W + 1;
    localparam int EW      = aarm_pkg::ENTRY_W;

    localparam logic signed [C_W-1:0]   ONE_F    = C_W'(1) <<< FRAC_BITS;
    localparam logic signed [PT_W-1:0]  HALF_F   = PT_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PT_W-1:0]  HALF_2F  = PT_W'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO   = SUM_W'(-32768);

    function automatic logic [EW-1:0] sat_entry(input logic signed [SUM_W-1:0] v);
        logic [EW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[EW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[EW-1:0];
        end else begin
            r = v[EW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [TERM_W-1:0] round_term(
        input logic signed [PT_W-1:0] v,
        input logic signed [PT_W-1:0] half,
        input int unsigned            sh
    );
        logic signed [PT_W-1:0] t;
        t = (v + half) >>> sh;
        return t[TERM_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Elastic handshake: a stage loads when it is empty or the next one moves.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: map the quadrant and round cosine and sine to Q.F.
    logic signed [W33-1:0] c30_w;
    logic signed [W33-1:0] s30_w;
    logic signed [W33-1:0] c_rnd;
    logic signed [W33-1:0] s_rnd;

    always_comb begin
        case (in_data.quad)
            aarm_pkg::QUAD_FIRST: begin
                c30_w = W33'(in_data.x);
                s30_w = W33'(in_data.y);
            end
            aarm_pkg::QUAD_SECOND: begin
                c30_w = -W33'(in_data.y);
                s30_w = W33'(in_data.x);
            end
            aarm_pkg::QUAD_THIRD: begin
                c30_w = -W33'(in_data.x);
                s30_w = -W33'(in_data.y);
            end
            default: begin
                c30_w = W33'(in_data.y);
                s30_w = -W33'(in_data.x);
            end
        endcase
    end

    if (RND_SH == 0) begin : g_no_round
        assign c_rnd = c30_w;
        assign s_rnd = s30_w;
    end else begin : g_round
        localparam logic signed [W33-1:0] HALF_C = W33'(1) <<< (RND_SH - 1);
        assign c_rnd = (c30_w + HALF_C) >>> RND_SH;
        assign s_rnd = (s30_w + HALF_C) >>> RND_SH;
    end

    logic signed [C_W-1:0]              c1_reg;
    logic signed [C_W-1:0]              s1_reg;
    logic signed [aarm_pkg::AXIS_W-1:0] ax1_reg;
    logic signed [aarm_pkg::AXIS_W-1:0] ay1_reg;
    logic signed [aarm_pkg::AXIS_W-1:0] az1_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            c1_reg  <= c_rnd[C_W-1:0];
            s1_reg  <= s_rnd[C_W-1:0];
            ax1_reg <= in_data.ax;
            ay1_reg <= in_data.ay;
            az1_reg <= in_data.az;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: one minus cosine, axis pair products, axis times sine.
    logic signed [C_W-1:0]  c2_reg, omc2_reg;
    logic signed [PQ_W-1:0] pxx2_reg, pxy2_reg, pxz2_reg, pyy2_reg, pyz2_reg, pzz2_reg;
    logic signed [SP_W-1:0] sax2_reg, say2_reg, saz2_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            c2_reg   <= c1_reg;
            omc2_reg <= ONE_F - c1_reg;
            pxx2_reg <= ax1_reg * ax1_reg;
            pxy2_reg <= ax1_reg * ay1_reg;
            pxz2_reg <= ax1_reg * az1_reg;
            pyy2_reg <= ay1_reg * ay1_reg;
            pyz2_reg <= ay1_reg * az1_reg;
            pzz2_reg <= az1_reg * az1_reg;
            sax2_reg <= ax1_reg * s1_reg;
            say2_reg <= ay1_reg * s1_reg;
            saz2_reg <= az1_reg * s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pair products times (1 - c); sine terms rounded to Q.F.
    logic signed [C_W-1:0]    c3_reg;
    logic signed [PT_W-1:0]   pxx3_reg, pxy3_reg, pxz3_reg, pyy3_reg, pyz3_reg, pzz3_reg;
    logic signed [TERM_W-1:0] sx3_reg, sy3_reg, sz3_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            c3_reg   <= c2_reg;
            pxx3_reg <= pxx2_reg * omc2_reg;
            pxy3_reg <= pxy2_reg * omc2_reg;
            pxz3_reg <= pxz2_reg * omc2_reg;
            pyy3_reg <= pyy2_reg * omc2_reg;
            pyz3_reg <= pyz2_reg * omc2_reg;
            pzz3_reg <= pzz2_reg * omc2_reg;
            sx3_reg  <= round_term(PT_W'(sax2_reg), HALF_F, FRAC_BITS);
            sy3_reg  <= round_term(PT_W'(say2_reg), HALF_F, FRAC_BITS);
            sz3_reg  <= round_term(PT_W'(saz2_reg), HALF_F, FRAC_BITS);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round the Q.3F products to Q.F.
    logic signed [TERM_W-1:0] c4_reg;
    logic signed [TERM_W-1:0] pxx4_reg, pxy4_reg, pxz4_reg, pyy4_reg, pyz4_reg, pzz4_reg;
    logic signed [TERM_W-1:0] sx4_reg, sy4_reg, sz4_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            c4_reg   <= TERM_W'(c3_reg);
            pxx4_reg <= round_term(pxx3_reg, HALF_2F, 2 * FRAC_BITS);
            pxy4_reg <= round_term(pxy3_reg, HALF_2F, 2 * FRAC_BITS);
            pxz4_reg <= round_term(pxz3_reg, HALF_2F, 2 * FRAC_BITS);
            pyy4_reg <= round_term(pyy3_reg, HALF_2F, 2 * FRAC_BITS);
            pyz4_reg <= round_term(pyz3_reg, HALF_2F, 2 * FRAC_BITS);
            pzz4_reg <= round_term(pzz3_reg, HALF_2F, 2 * FRAC_BITS);
            sx4_reg  <= sx3_reg;
            sy4_reg  <= sy3_reg;
            sz4_reg  <= sz3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add the terms, saturate, and pack column-major.
    logic signed [SUM_W-1:0] e_next [aarm_pkg::NUM_ENTRIES];
    logic [aarm_pkg::M_TDATA_W-1:0] out_reg;

    always_comb begin
        e_next[0] = SUM_W'(c4_reg)   + SUM_W'(pxx4_reg);
        e_next[1] = SUM_W'(pxy4_reg) + SUM_W'(sz4_reg);
        e_next[2] = SUM_W'(pxz4_reg) - SUM_W'(sy4_reg);
        e_next[3] = SUM_W'(pxy4_reg) - SUM_W'(sz4_reg);
        e_next[4] = SUM_W'(c4_reg)   + SUM_W'(pyy4_reg);
        e_next[5] = SUM_W'(pyz4_reg) + SUM_W'(sx4_reg);
        e_next[6] = SUM_W'(pxz4_reg) + SUM_W'(sy4_reg);
        e_next[7] = SUM_W'(pyz4_reg) - SUM_W'(sx4_reg);
        e_next[8] = SUM_W'(c4_reg)   + SUM_W'(pzz4_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            for (int k = 0; k < aarm_pkg::NUM_ENTRIES; k++) begin
                out_reg[k*EW +: EW] <= sat_entry(e_next[k]);
            end
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix_unit.sv =====
// Top level of the axis-angle rotation matrix unit: stream ports, the CORDIC
// cell chain and the matrix builder. Depends on aarm_pkg, aarm_cordic_cell, aarm_matrix.
`default_nettype none

// Takes one beat per cycle while the output is not held back, holding a Q2.14
// axis and an angle in fractions of a turn, and returns one beat with the nine
// entries of the 3x3 rotation matrix (column-major, Q2.14, saturated). Sine and
// cosine come from a chain of CORDIC_STAGES cells, one micro-rotation per cell,
// followed by five matrix stages. Every stage has its own valid bit and holds
// its data under backpressure; the input keeps accepting until every stage is
// full, and the output register lets a finished beat wait while the stages
// behind it keep moving only into the empty stages ahead of them.
module axis_angle_rotation_matrix_unit #(
    parameter int FRAC_BITS     = aarm_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS    = aarm_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle_turns [63:48]
    input  wire  [aarm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // c0_r0 [15:0], c0_r1 [31:16], c0_r2 [47:32], c1_r0 [63:48], c1_r1 [79:64],
    // c1_r2 [95:80], c2_r0 [111:96], c2_r1 [127:112], c2_r2 [143:128]
    output logic [aarm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready
);

    localparam int AW = aarm_pkg::AXIS_W;

    // Angle left-aligned to 32 bits of a turn; bits above ANGLE_BITS fall off.
    logic [aarm_pkg::TURN_W-1:0] ang_w;
    logic [aarm_pkg::TURN_W-1:0] turn32;
    assign ang_w  = aarm_pkg::TURN_W'(s_tdata[3*AW +: aarm_pkg::ANGLE_W]);
    assign turn32 = ang_w << (aarm_pkg::TURN_W - ANGLE_BITS);

    // Links between cells; link 0 is the start vector built from the input beat.
    aarm_pkg::cord_t link_data  [CORDIC_STAGES+1];
    logic            link_valid [CORDIC_STAGES+1];
    logic            link_ready [CORDIC_STAGES+1];

    always_comb begin
        link_data[0].x    = aarm_pkg::GAIN_Q30;
        link_data[0].y    = '0;
        link_data[0].z    = {2'b00, turn32[aarm_pkg::TURN_W-3:0]};
        link_data[0].quad = aarm_pkg::quad_t'(turn32[aarm_pkg::TURN_W-1 -: 2]);
        link_data[0].ax   = s_tdata[0 +: AW];
        link_data[0].ay   = s_tdata[AW +: AW];
        link_data[0].az   = s_tdata[2*AW +: AW];
    end

    assign link_valid[0] = s_tvalid;
    assign s_tready      = link_ready[0];

    // CORDIC cell chain.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        aarm_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // Matrix builder and output register.
    aarm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[CORDIC_STAGES]),
        .in_ready  (link_ready[CORDIC_STAGES]),
        .in_data   (link_data[CORDIC_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // The input stalls only when the output is held back.
    a_stall_needs_backpressure: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready)
    ) else $error("input stalled without output backpressure");

    // A draining output lets the whole chain move, so the input is open.
    a_drain_opens_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready
    ) else $error("input closed while output drains");

    // No result beat straight after reset.
    a_reset_empties: assert property (
        @(posedge aclk)
        !aresetn |=> !m_tvalid
    ) else $error("result beat shown right after reset");

endmodule

`default_nettype wire
